// ===== rtl/core/mio_pkg.sv =====
package mio_pkg;

   localparam int TIME_W            = 12;
   localparam int OUT_W             = 8;
   localparam int MAX_INTERVALS_DEF = 128;
   localparam logic [OUT_W-1:0] OUT_SAT = '1;

   typedef struct packed {
      logic wr;
      logic clear;
      logic scan;
      logic latch_t;
      logic acc;
      logic acc_clr;
      logic upd_best;
      logic best_clr;
      logic i_clr;
      logic i_inc;
      logic j_clr;
      logic j_inc;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic i_last;
      logic j_last;
   } status_type;

endpackage

// ===== rtl/core/mio_dp.sv =====
module mio_dp #(
   parameter int MAX_INTERVALS = mio_pkg::MAX_INTERVALS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mio_pkg::cmd_type              cmd,
   output mio_pkg::status_type           status,
   input  logic [mio_pkg::TIME_W-1:0]    arrival_time,
   input  logic [mio_pkg::TIME_W-1:0]    departure_time,
   output logic [mio_pkg::OUT_W-1:0]     max_overlap,
   output logic                          overflow
);

   localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_INTERVALS);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   logic [mio_pkg::TIME_W-1:0] start_mem [MAX_INTERVALS];
   logic [mio_pkg::TIME_W-1:0] end_mem   [MAX_INTERVALS];

   logic [CW-1:0]              count_ff;
   logic                       drop_ff;
   logic [AW-1:0]              i_ff;
   logic [AW-1:0]              j_ff;
   logic [AW-1:0]              rd_addr;
   logic [mio_pkg::TIME_W-1:0] rd_s_ff;
   logic [mio_pkg::TIME_W-1:0] rd_e_ff;
   logic [mio_pkg::TIME_W-1:0] ta_ff;
   logic [mio_pkg::TIME_W-1:0] tb_ff;
   logic [CW-1:0]              ca_ff;
   logic [CW-1:0]              cb_ff;
   logic [CW-1:0]              best_ff;
   logic [CW-1:0]              best_in;
   logic                       acc_en_ff;
   logic [mio_pkg::OUT_W-1:0]  out_ff;
   logic [mio_pkg::OUT_W-1:0]  out_in;
   logic                       ovf_ff;
   logic                       hit_a;
   logic                       hit_b;

   assign rd_addr = cmd.scan ? j_ff : i_ff;
   assign hit_a   = (ta_ff >= rd_s_ff) && (ta_ff <= rd_e_ff);
   assign hit_b   = (tb_ff >= rd_s_ff) && (tb_ff <= rd_e_ff);

   assign status.i_last = (CW'(i_ff) == count_ff - CNT_ONE);
   assign status.j_last = (CW'(j_ff) == count_ff - CNT_ONE);

   always_comb begin
      best_in = best_ff;
      if (ca_ff > best_in) begin
         best_in = ca_ff;
      end
      if (cb_ff > best_in) begin
         best_in = cb_ff;
      end
      if (32'(best_ff) > 32'(mio_pkg::OUT_SAT)) begin
         out_in = mio_pkg::OUT_SAT;
      end else begin
         out_in = mio_pkg::OUT_W'(best_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr && (count_ff != CNT_MAX)) begin
         start_mem[count_ff[AW-1:0]] <= arrival_time;
         end_mem[count_ff[AW-1:0]]   <= departure_time;
      end
      rd_s_ff <= start_mem[rd_addr];
      rd_e_ff <= end_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.acc;
         if (cmd.clear) begin
            count_ff <= '0;
            drop_ff  <= 1'b0;
         end else if (cmd.wr) begin
            if (count_ff != CNT_MAX) begin
               count_ff <= count_ff + CNT_ONE;
            end else begin
               drop_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.i_clr) begin
         i_ff <= '0;
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + AW'(1);
      end
      if (cmd.j_clr) begin
         j_ff <= '0;
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + AW'(1);
      end
      if (cmd.latch_t) begin
         ta_ff <= rd_s_ff;
         tb_ff <= rd_e_ff;
      end
      if (cmd.acc_clr) begin
         ca_ff <= '0;
         cb_ff <= '0;
      end else if (acc_en_ff) begin
         ca_ff <= ca_ff + CW'(hit_a);
         cb_ff <= cb_ff + CW'(hit_b);
      end
      if (cmd.best_clr) begin
         best_ff <= '0;
      end else if (cmd.upd_best) begin
         best_ff <= best_in;
      end
      if (cmd.load_out) begin
         out_ff <= out_in;
         ovf_ff <= drop_ff;
      end
   end

   assign max_overlap = out_ff;
   assign overflow    = ovf_ff;

endmodule

// ===== rtl/core/mio_ctrl.sv =====
module mio_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   input  mio_pkg::status_type status,
   output mio_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      FETCH,
      LOAD,
      SCAN,
      DRAIN,
      UPDATE,
      DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.wr = 1'b1;
               if (req_tlast) begin
                  cmd.i_clr    = 1'b1;
                  cmd.best_clr = 1'b1;
                  state_in     = FETCH;
               end
            end
         end
         FETCH: begin
            state_in = LOAD;
         end
         LOAD: begin
            cmd.latch_t = 1'b1;
            cmd.acc_clr = 1'b1;
            cmd.j_clr   = 1'b1;
            state_in    = SCAN;
         end
         SCAN: begin
            cmd.scan = 1'b1;
            cmd.acc  = 1'b1;
            if (status.j_last) begin
               state_in = DRAIN;
            end else begin
               cmd.j_inc = 1'b1;
            end
         end
         DRAIN: begin
            state_in = UPDATE;
         end
         UPDATE: begin
            cmd.upd_best = 1'b1;
            if (status.i_last) begin
               state_in = DONE;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = FETCH;
            end
         end
         DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/max_interval_overlap.sv =====
// Maximum interval overlap: number of seats needed for a set of closed intervals.
// Request channel: one interval per transfer. req_tdata carries arrival_time in
// [11:0] and departure_time in [23:12]; req_tlast marks the final interval of a set.
// While idle, intervals load at one per cycle into two on-chip memories of MAX_INTERVALS
// entries; once the store is full, further intervals of the set are dropped and flagged.
// After the last interval the sequencer walks every stored interval i, reads both of
// its endpoints and scans all n stored intervals through one shared read address,
// counting containment for both endpoints in parallel. No request is taken during
// the pass.
// Response channel: rsp_tdata[7:0] is max_overlap (saturated at 255), rsp_tuser is
// overflow. The result sits in an output register: new intervals are accepted while
// it waits, and only the next set's completion waits on rsp_tready.
// Reset (synchronous, active high) empties the store, clears the overflow flag and
// drops any pending response; memory contents are not cleared.
module max_interval_overlap #(
   parameter int MAX_INTERVALS = mio_pkg::MAX_INTERVALS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // arrival_time[11:0], departure_time[23:12]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // max_overlap[7:0]
   output logic        rsp_tuser    // overflow[0]
);

   mio_pkg::cmd_type    cmd;
   mio_pkg::status_type status;

   mio_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   mio_dp #(
      .MAX_INTERVALS (MAX_INTERVALS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .arrival_time   (req_tdata[11:0]),
      .departure_time (req_tdata[23:12]),
      .max_overlap    (rsp_tdata),
      .overflow       (rsp_tuser)
   );

`ifndef NO_ASSERTIONS
   a_wr_on_transfer: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> (req_tvalid && req_tready))
      else $error("store write without request transfer");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten while pending");

   a_scan_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> !req_tready)
      else $error("request accepted during count pass");
`endif

endmodule
